// File: rtl/core/ptts_pkg.sv
// package for the pid table and tuning status block
// holds codes, parameter masks, controller/datapath structs and the completeness check
// no dependencies
package ptts_pkg;

    // action codes
    localparam logic [2:0] ACT_ADD    = 3'd0;
    localparam logic [2:0] ACT_DEL    = 3'd1;
    localparam logic [2:0] ACT_DELALL = 3'd2;
    localparam logic [2:0] ACT_SETTLE = 3'd3;
    localparam logic [2:0] ACT_SETPAR = 3'd4;
    localparam logic [2:0] ACT_LNBOFF = 3'd5;
    localparam logic [2:0] ACT_CLEAR  = 3'd6;
    localparam logic [2:0] ACT_READ   = 3'd7;

    // entry marks
    localparam logic [1:0] MK_VALID = 2'd0;
    localparam logic [1:0] MK_FREE  = 2'd1;
    localparam logic [1:0] MK_ADD   = 2'd2;
    localparam logic [1:0] MK_DEL   = 2'd3;

    // status codes
    localparam logic [1:0] ST_SETTLED    = 2'd0;
    localparam logic [1:0] ST_PIDCHG     = 2'd1;
    localparam logic [1:0] ST_CHANGED    = 2'd2;
    localparam logic [1:0] ST_INCOMPLETE = 2'd3;

    // frontend types
    localparam logic [1:0] FE_SAT   = 2'd0;
    localparam logic [1:0] FE_TERR  = 2'd1;
    localparam logic [1:0] FE_CABLE = 2'd2;

    // modulation system codes
    localparam logic [31:0] MS_S  = 32'd0;
    localparam logic [31:0] MS_S2 = 32'd1;
    localparam logic [31:0] MS_T  = 32'd2;
    localparam logic [31:0] MS_T2 = 32'd3;
    localparam logic [31:0] MS_C  = 32'd4;

    // parameter selectors with special handling
    localparam logic [3:0] SEL_POL    = 4'd1;
    localparam logic [3:0] SEL_MODSYS = 4'd3;

    // presence bits
    localparam logic [15:0] B_FREQ     = 16'h0001;
    localparam logic [15:0] B_POL      = 16'h0002;
    localparam logic [15:0] B_ROLLOFF  = 16'h0004;
    localparam logic [15:0] B_MODSYS   = 16'h0008;
    localparam logic [15:0] B_MODTYPE  = 16'h0010;
    localparam logic [15:0] B_PILOTS   = 16'h0020;
    localparam logic [15:0] B_SYMRATE  = 16'h0040;
    localparam logic [15:0] B_FEC      = 16'h0080;
    localparam logic [15:0] B_POSITION = 16'h0100;
    localparam logic [15:0] B_GUARD    = 16'h0200;
    localparam logic [15:0] B_TMODE    = 16'h0400;
    localparam logic [15:0] B_BW       = 16'h0800;
    localparam logic [15:0] B_PLP      = 16'h2000;

    localparam logic [15:0] NEED_S  = B_FREQ | B_POL | B_MODSYS | B_SYMRATE | B_FEC | B_POSITION;
    localparam logic [15:0] NEED_S2 = NEED_S | B_ROLLOFF | B_MODTYPE | B_PILOTS;
    localparam logic [15:0] NEED_T  = B_FREQ | B_MODSYS | B_MODTYPE | B_FEC | B_GUARD
                                    | B_TMODE | B_BW;
    localparam logic [15:0] NEED_T2 = NEED_T | B_PLP;
    localparam logic [15:0] NEED_C  = B_FREQ | B_MODSYS | B_MODTYPE | B_SYMRATE;

    // controller to datapath
    typedef struct packed {
        logic load;   // latch the input beat
        logic rd;     // issue a table read, advance address
        logic apply;  // final update of the item
        logic fin;    // pid status update
        logic emit;   // load the output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_sweep;
        logic last;
    } t_stat;

    function automatic logic tune_ok(input logic [15:0] m, input logic [31:0] ms,
                                     input logic [1:0] ft);
        logic ok;
        ok = 1'b0;
        if ((m & B_MODSYS) != 16'h0) begin
            case (ft)
                FE_SAT: begin
                    ok = (ms == MS_S && (m & NEED_S) == NEED_S) ||
                         (ms == MS_S2 && (m & NEED_S2) == NEED_S2);
                end
                FE_TERR: begin
                    ok = (ms == MS_T && (m & NEED_T) == NEED_T) ||
                         (ms == MS_T2 && (m & NEED_T2) == NEED_T2);
                end
                FE_CABLE: begin
                    ok = (ms == MS_C && (m & NEED_C) == NEED_C);
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end
        return ok;
    endfunction

endpackage

// File: rtl/core/ptts_ctrl.sv
// controller state machine for the pid table block
// sequences load, table sweep, apply, status update and result beat
// depends on ptts_pkg
module ptts_ctrl import ptts_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_DRAIN = 6'b000100,
        S_APPLY = 6'b001000,
        S_FIN   = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_init;
    logic   r_out_vld;
    logic   accept;
    logic   slot_free;

    assign accept    = i_in_valid && (r_state == S_IDLE);
    assign slot_free = !r_out_vld || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_cmd.load  = accept;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = i_stat.need_sweep ? S_SCAN : S_APPLY;
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_stat.last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = r_init ? S_IDLE : S_EMIT;
            end
            S_EMIT: begin
                if (slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_SCAN;
            r_init    <= 1'b1;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_FIN) r_init <= 1'b0;
            if (o_cmd.emit) r_out_vld <= 1'b1;
            else if (!i_out_stall) r_out_vld <= 1'b0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;

endmodule

// File: rtl/core/ptts_dpath.sv
// datapath for the pid table block: entry memories, sweep logic, tuning registers
// and the result register
// depends on ptts_pkg
module ptts_dpath import ptts_pkg::*; #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    input  logic [1:0]  i_frontend_type,
    input  logic [2:0]  i_action,
    input  logic [12:0] i_stream_pid,
    input  logic [3:0]  i_param_select,
    input  logic [31:0] i_param_word,
    input  logic [4:0]  i_entry_select,
    output logic [1:0]  o_status_code,
    output logic        o_failed,
    output logic [12:0] o_entry_pid_out,
    output logic [1:0]  o_entry_mark_out
);

    localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_ENTRIES - 1);
    localparam logic [CW-1:0] ONE_CNT   = CW'(1);

    logic [12:0] pid_mem  [TABLE_ENTRIES];
    logic [1:0]  mark_mem [TABLE_ENTRIES];

    // latched beat
    logic [2:0]  r_act;
    logic [12:0] r_pid;
    logic [3:0]  r_sel;
    logic [31:0] r_word;
    logic [4:0]  r_esel;

    // sweep
    logic [AW-1:0] r_addr, r_raddr;
    logic          r_rvld;
    logic [12:0]   r_rd_pid;
    logic [1:0]    r_rd_mark;
    logic          r_hit, r_free;
    logic [AW-1:0] r_hit_idx, r_free_idx;
    logic [1:0]    r_hit_mark;
    logic          r_changed;
    logic [CW-1:0] r_acc;

    // block state
    logic [1:0]    r_status, n_status;
    logic [15:0]   r_mask, n_mask;
    logic          r_lnb, n_lnb;
    logic [CW-1:0] r_pend, n_pend;
    logic [31:0]   r_param [16];
    logic          r_pchg, n_pchg;
    logic          r_failed, n_failed;
    logic [12:0]   r_res_pid;
    logic [1:0]    r_res_mark;

    // result register
    logic [1:0]  r_out_status;
    logic        r_out_failed;
    logic [12:0] r_out_pid;
    logic [1:0]  r_out_mark;

    logic [31:0]   esel_ext;
    logic          esel_oor;
    logic          swe;
    logic [1:0]    swd;
    logic          awe, awpid;
    logic [AW-1:0] awa;
    logic [1:0]    awd;
    logic          we;
    logic [AW-1:0] wa;
    logic [1:0]    wd;
    logic [15:0]   sel_bit;
    logic [15:0]   set_mask;
    logic [31:0]   set_ms;
    logic          same_val;

    assign esel_ext = {27'd0, i_entry_select};
    assign esel_oor = {27'd0, r_esel} >= 32'(TABLE_ENTRIES);

    always_comb begin
        o_stat.need_sweep = 1'b1;
        if (i_action == ACT_SETTLE)
            o_stat.need_sweep = (r_status == ST_CHANGED) || (r_status == ST_PIDCHG);
        else if (i_action == ACT_SETPAR || i_action == ACT_LNBOFF)
            o_stat.need_sweep = 1'b0;
        o_stat.last = (r_act == ACT_READ) || (r_addr == LAST_ADDR);
    end

    // per-entry update while sweeping
    always_comb begin
        swe = 1'b0;
        swd = r_rd_mark;
        if (r_rvld) begin
            case (r_act)
                ACT_DELALL: begin
                    if (r_rd_mark == MK_VALID) begin
                        swe = 1'b1;
                        swd = MK_DEL;
                    end else if (r_rd_mark == MK_ADD) begin
                        swe = 1'b1;
                        swd = MK_FREE;
                    end
                end
                ACT_SETTLE: begin
                    if (r_rd_mark == MK_ADD) begin
                        swe = 1'b1;
                        swd = MK_VALID;
                    end else if (r_rd_mark == MK_DEL) begin
                        swe = 1'b1;
                        swd = MK_FREE;
                    end
                end
                ACT_CLEAR: begin
                    swe = 1'b1;
                    swd = MK_FREE;
                end
                default: begin
                    swe = 1'b0;
                end
            endcase
        end
    end

    // final update of one item
    assign sel_bit  = 16'(1) << r_sel;
    assign set_mask = r_mask | sel_bit;
    assign set_ms   = (r_sel == SEL_MODSYS) ? r_word : r_param[SEL_MODSYS];
    assign same_val = ((r_mask & sel_bit) != 16'h0) && (r_param[r_sel] == r_word);

    always_comb begin
        n_status = r_status;
        n_mask   = r_mask;
        n_lnb    = r_lnb;
        n_pend   = r_pend;
        n_pchg   = 1'b0;
        n_failed = 1'b0;
        awe      = 1'b0;
        awpid    = 1'b0;
        awa      = r_hit_idx;
        awd      = MK_VALID;
        case (r_act)
            ACT_ADD: begin
                if (r_hit) begin
                    if (r_hit_mark == MK_DEL) begin
                        awe    = 1'b1;
                        n_pend = r_pend - ONE_CNT;
                        n_pchg = 1'b1;
                    end
                end else if (r_free) begin
                    awe    = 1'b1;
                    awpid  = 1'b1;
                    awa    = r_free_idx;
                    awd    = MK_ADD;
                    n_pend = r_pend + ONE_CNT;
                    n_pchg = 1'b1;
                end else begin
                    n_failed = 1'b1;
                end
            end
            ACT_DEL: begin
                if (r_hit && r_hit_mark == MK_VALID) begin
                    awe    = 1'b1;
                    awd    = MK_DEL;
                    n_pend = r_pend + ONE_CNT;
                    n_pchg = 1'b1;
                end else if (r_hit && r_hit_mark == MK_ADD) begin
                    awe    = 1'b1;
                    awd    = MK_FREE;
                    n_pend = r_pend - ONE_CNT;
                    n_pchg = 1'b1;
                end
            end
            ACT_DELALL: begin
                n_pend = r_acc;
                n_pchg = r_changed;
            end
            ACT_SETTLE: begin
                if (r_status == ST_INCOMPLETE) begin
                    n_failed = 1'b1;
                end else if (r_status != ST_SETTLED) begin
                    n_pend   = '0;
                    n_status = ST_SETTLED;
                end
            end
            ACT_SETPAR: begin
                if (!same_val) begin
                    n_mask = set_mask;
                    if (r_sel != SEL_POL || r_lnb) begin
                        n_lnb    = (r_sel == SEL_POL) ? 1'b0 : r_lnb;
                        n_status = tune_ok(set_mask, set_ms, i_frontend_type)
                                 ? ST_CHANGED : ST_INCOMPLETE;
                    end
                end
            end
            ACT_LNBOFF: begin
                n_lnb    = 1'b1;
                n_mask   = r_mask & ~B_POL;
                n_status = ST_INCOMPLETE;
            end
            ACT_CLEAR: begin
                n_status = ST_INCOMPLETE;
                n_mask   = '0;
                n_lnb    = 1'b0;
                n_pend   = '0;
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    assign we = swe || (i_cmd.apply && awe);
    assign wa = swe ? r_raddr : awa;
    assign wd = swe ? swd : awd;

    // table memories
    always_ff @(posedge i_clk) begin
        if (we) mark_mem[wa] <= wd;
        if (i_cmd.apply && awe && awpid) pid_mem[awa] <= r_pid;
        if (i_cmd.rd) begin
            r_rd_mark <= mark_mem[r_addr];
            r_rd_pid  <= pid_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act    <= ACT_CLEAR;
            r_addr   <= '0;
            r_rvld   <= 1'b0;
            r_status <= ST_INCOMPLETE;
            r_mask   <= '0;
            r_lnb    <= 1'b0;
            r_pend   <= '0;
            r_pchg   <= 1'b0;
            r_failed <= 1'b0;
        end else begin
            r_rvld <= i_cmd.rd;
            if (i_cmd.load) begin
                r_act    <= i_action;
                r_addr   <= (i_action == ACT_READ) ? esel_ext[AW-1:0] : '0;
                r_failed <= 1'b0;
            end else if (i_cmd.rd) begin
                r_addr <= r_addr + AW'(1);
            end
            if (i_cmd.apply) begin
                r_status <= n_status;
                r_mask   <= n_mask;
                r_lnb    <= n_lnb;
                r_pend   <= n_pend;
                r_pchg   <= n_pchg;
                r_failed <= n_failed;
            end
            // pid status update after mark changes
            if (i_cmd.fin && r_pchg) begin
                if (r_status == ST_SETTLED && r_pend != '0) r_status <= ST_PIDCHG;
                else if (r_status == ST_PIDCHG && r_pend == '0) r_status <= ST_SETTLED;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_raddr <= r_addr;
        if (i_cmd.load) begin
            r_pid      <= i_stream_pid;
            r_sel      <= i_param_select;
            r_word     <= i_param_word;
            r_esel     <= i_entry_select;
            r_hit      <= 1'b0;
            r_free     <= 1'b0;
            r_changed  <= 1'b0;
            r_acc      <= '0;
            r_res_pid  <= '0;
            r_res_mark <= MK_VALID;
        end else if (r_rvld) begin
            if (!r_hit && r_rd_mark != MK_FREE && r_rd_pid == r_pid) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= r_raddr;
                r_hit_mark <= r_rd_mark;
            end
            if (!r_free && r_rd_mark == MK_FREE) begin
                r_free     <= 1'b1;
                r_free_idx <= r_raddr;
            end
            if (swe) r_changed <= 1'b1;
            if (r_rd_mark == MK_VALID || r_rd_mark == MK_DEL) r_acc <= r_acc + ONE_CNT;
            if (r_act == ACT_READ) begin
                r_res_pid  <= esel_oor ? 13'd0 : r_rd_pid;
                r_res_mark <= esel_oor ? MK_FREE : r_rd_mark;
            end
        end
        if (i_cmd.apply && r_act == ACT_SETPAR && !same_val) r_param[r_sel] <= r_word;
        if (i_cmd.emit) begin
            r_out_status <= r_status;
            r_out_failed <= r_failed;
            r_out_pid    <= r_res_pid;
            r_out_mark   <= r_res_mark;
        end
    end

    assign o_status_code    = r_out_status;
    assign o_failed         = r_out_failed;
    assign o_entry_pid_out  = r_out_pid;
    assign o_entry_mark_out = r_out_mark;

    // pending count stays within the table
    a_pend_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= CW'(TABLE_ENTRIES))
        else $error("pending count beyond table size");

    // clear always leaves the status incomplete
    a_clear_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.apply && r_act == ACT_CLEAR) |=> (r_status == ST_INCOMPLETE))
        else $error("clear did not force incomplete");

    // failure comes only from add or settle
    a_failed_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (r_act == ACT_ADD || r_act == ACT_SETTLE))
        else $error("failed set by wrong action");

endmodule

// File: rtl/core/pid_table_and_tuning_status.sv
// top level of the pid table and tuning status block
// joins controller, datapath and the apb configuration register
// depends on ptts_pkg, ptts_ctrl, ptts_dpath
//
//  channel   direction  handshake                    payload
//  input     in         i_in_valid / o_in_stall      action, pid, param select/word, entry
//  result    out        o_out_valid / i_out_stall    status, failed, entry pid/mark, flags
//  config    in         psel/penable/pwrite/pready   frontend_type at byte address 0
//
//  add, delete, delete all, clear and a settle from pid or tuning changed sweep the table
//  with one mark/pid memory read per cycle; read entry reads only the selected entry, the
//  rest skip the sweep; after each result the block returns to idle and takes the next beat
//  after reset a clearing pass marks every entry free,
//  no beat is taken meanwhile
//  a stalled result beat holds in the output register; the next beat is taken meanwhile
//  and finishes up to the point of loading its result
module pid_table_and_tuning_status import ptts_pkg::*; #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input beat
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [12:0] i_stream_pid,
    input  logic [3:0]  i_param_select,
    input  logic [31:0] i_param_word,
    input  logic [4:0]  i_entry_select,
    // result beat
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status_code,
    output logic        o_failed,
    output logic [12:0] o_entry_pid_out,
    output logic [1:0]  o_entry_mark_out,
    output logic        o_config_valid,
    output logic        o_tuning_needed,
    output logic        o_pid_update_needed,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cmd       cmd;
    t_stat      stat;
    logic [1:0] r_frontend_type;

    // frontend type register, register 0 at byte address 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frontend_type <= 2'd3;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_frontend_type <= pwdata[1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {30'd0, r_frontend_type} : 32'd0;

    ptts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    ptts_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_frontend_type  (r_frontend_type),
        .i_action         (i_action),
        .i_stream_pid     (i_stream_pid),
        .i_param_select   (i_param_select),
        .i_param_word     (i_param_word),
        .i_entry_select   (i_entry_select),
        .o_status_code    (o_status_code),
        .o_failed         (o_failed),
        .o_entry_pid_out  (o_entry_pid_out),
        .o_entry_mark_out (o_entry_mark_out)
    );

    // status flags decoded from the registered status
    assign o_config_valid      = (o_status_code != ST_INCOMPLETE);
    assign o_tuning_needed     = (o_status_code == ST_CHANGED);
    assign o_pid_update_needed = (o_status_code == ST_PIDCHG);

endmodule

// File: verif/pid_table_and_tuning_status_tb.sv
// testbench for pid_table_and_tuning_status: directed and random control beats,
// checked against a built-in predictor of the pid table and tuning status
// depends on ptts_pkg and the rtl of the block
`timescale 1ns / 1ps

module pid_table_and_tuning_status_tb;
    import ptts_pkg::*;

    // one result beat as the block should present it
    typedef struct packed {
        logic [1:0]  status;
        logic        failed;
        logic [12:0] epid;
        logic [1:0]  emark;
        logic        cfg_ok;
        logic        tune;
        logic        pidupd;
    } t_res;

    // scoreboard: mirrors table, parameters and status; holds pending results
    class ptts_scoreboard;
        logic [12:0] pids[32];
        logic [1:0]  marks[32];
        bit          written[32];
        logic [1:0]  status;
        logic [15:0] mask;
        logic [31:0] vals[16];
        bit          lnb_off;
        logic [1:0]  fe;
        t_res        pending_q[$];
        int          errors;
        int          results;

        function new();
            for (int i = 0; i < 32; i++) begin
                marks[i]   = MK_FREE;
                pids[i]    = '0;
                written[i] = 0;
            end
            for (int i = 0; i < 16; i++) vals[i] = '0;
            status  = ST_INCOMPLETE;
            mask    = '0;
            lnb_off = 0;
            fe      = 2'd3;
            errors  = 0;
            results = 0;
        endfunction

        // pending marks push settled/pid changed back and forth
        function void refresh_pid_status();
            bit busy;
            busy = 0;
            foreach (marks[i]) if (marks[i] == MK_ADD || marks[i] == MK_DEL) busy = 1;
            if (status == ST_SETTLED && busy) status = ST_PIDCHG;
            else if (status == ST_PIDCHG && !busy) status = ST_SETTLED;
        endfunction

        function bit covers(logic [15:0] need);
            return (mask & need) == need;
        endfunction

        function void refresh_tuning();
            bit ok;
            logic [31:0] ms;
            ok = 0;
            ms = vals[SEL_MODSYS];
            if (mask & B_MODSYS) begin
                case (fe)
                    FE_SAT:   ok = (ms == MS_S && covers(NEED_S)) ||
                                   (ms == MS_S2 && covers(NEED_S2));
                    FE_TERR:  ok = (ms == MS_T && covers(NEED_T)) ||
                                   (ms == MS_T2 && covers(NEED_T2));
                    FE_CABLE: ok = (ms == MS_C && covers(NEED_C));
                    default:  ok = 0;
                endcase
            end
            status = ok ? ST_CHANGED : ST_INCOMPLETE;
        endfunction

        function int live_slot(logic [12:0] pid);
            for (int i = 0; i < 32; i++)
                if (marks[i] != MK_FREE && pids[i] == pid) return i;
            return -1;
        endfunction

        // a written entry to read back, or -1 when none exists yet
        function int readable_slot();
            int n;
            int idx;
            n = 0;
            foreach (written[i]) if (written[i]) n++;
            if (n == 0) return -1;
            idx = $urandom_range(n - 1);
            foreach (written[i]) if (written[i]) begin
                if (idx == 0) return i;
                idx--;
            end
            return -1;
        endfunction

        function bit idle();
            return pending_q.size() == 0;
        endfunction

        // accepted input beat: update the mirror and queue the result it causes
        function void note_input(logic [2:0] act, logic [12:0] pid, logic [3:0] sel,
                                 logic [31:0] word, logic [4:0] esel);
            t_res r;
            int k;
            bit chg;
            r.failed = 0;
            r.epid   = '0;
            r.emark  = '0;
            case (act)
                ACT_ADD: begin
                    k = live_slot(pid);
                    if (k >= 0) begin
                        if (marks[k] == MK_DEL) begin
                            marks[k] = MK_VALID;
                            refresh_pid_status();
                        end
                    end else begin
                        r.failed = 1;
                        for (int i = 0; i < 32; i++) if (marks[i] == MK_FREE) begin
                            marks[i]   = MK_ADD;
                            pids[i]    = pid;
                            written[i] = 1;
                            refresh_pid_status();
                            r.failed = 0;
                            break;
                        end
                    end
                end
                ACT_DEL: begin
                    k = live_slot(pid);
                    if (k >= 0) begin
                        if (marks[k] == MK_VALID) begin
                            marks[k] = MK_DEL;
                            refresh_pid_status();
                        end else if (marks[k] == MK_ADD) begin
                            marks[k] = MK_FREE;
                            refresh_pid_status();
                        end
                    end
                end
                ACT_DELALL: begin
                    chg = 0;
                    foreach (marks[i]) begin
                        if (marks[i] == MK_VALID) begin
                            marks[i] = MK_DEL;
                            chg = 1;
                        end else if (marks[i] == MK_ADD) begin
                            marks[i] = MK_FREE;
                            chg = 1;
                        end
                    end
                    if (chg) refresh_pid_status();
                end
                ACT_SETTLE: begin
                    if (status == ST_CHANGED || status == ST_PIDCHG) begin
                        foreach (marks[i]) begin
                            if (marks[i] == MK_ADD) marks[i] = MK_VALID;
                            else if (marks[i] == MK_DEL) marks[i] = MK_FREE;
                        end
                        status = ST_SETTLED;
                    end else if (status == ST_INCOMPLETE) begin
                        r.failed = 1;
                    end
                end
                ACT_SETPAR: begin
                    // same value rewritten leaves everything alone
                    if (!(mask[sel] && vals[sel] == word)) begin
                        mask[sel] = 1'b1;
                        vals[sel] = word;
                        if (sel == SEL_POL) begin
                            if (lnb_off) begin
                                lnb_off = 0;
                                refresh_tuning();
                            end
                        end else begin
                            refresh_tuning();
                        end
                    end
                end
                ACT_LNBOFF: begin
                    lnb_off = 1;
                    mask    = mask & ~B_POL;
                    status  = ST_INCOMPLETE;
                end
                ACT_CLEAR: begin
                    status  = ST_INCOMPLETE;
                    mask    = '0;
                    lnb_off = 0;
                    foreach (marks[i]) marks[i] = MK_FREE;
                end
                default: begin
                    r.epid  = pids[esel];
                    r.emark = marks[esel];
                end
            endcase
            r.status = status;
            r.cfg_ok = status != ST_INCOMPLETE;
            r.tune   = status == ST_CHANGED;
            r.pidupd = status == ST_PIDCHG;
            pending_q.push_back(r);
        endfunction

        // accepted result beat against the oldest pending one
        function void check_result(t_res got);
            t_res w;
            results++;
            if (pending_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("result beat with nothing pending");
                return;
            end
            w = pending_q.pop_front();
            if (got != w) begin
                errors++;
                if (errors <= 10)
                    $display({"mismatch beat %0d: exp st=%0d f=%0d pid=%0d mk=%0d v=%0d",
                              " t=%0d p=%0d, got st=%0d f=%0d pid=%0d mk=%0d v=%0d",
                              " t=%0d p=%0d"},
                             results, w.status, w.failed, w.epid, w.emark, w.cfg_ok,
                             w.tune, w.pidupd, got.status, got.failed, got.epid,
                             got.emark, got.cfg_ok, got.tune, got.pidupd);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [2:0]  i_action;
    logic [12:0] i_stream_pid;
    logic [3:0]  i_param_select;
    logic [31:0] i_param_word;
    logic [4:0]  i_entry_select;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status_code;
    logic        o_failed;
    logic [12:0] o_entry_pid_out;
    logic [1:0]  o_entry_mark_out;
    logic        o_config_valid;
    logic        o_tuning_needed;
    logic        o_pid_update_needed;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ptts_scoreboard sb;
    bit  hold_req;      // asks the result side for one long hold-off
    bit  gapless;       // sender runs back to back for a stretch
    int  beats_sent;
    int  cfg_writes;

    pid_table_and_tuning_status i_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // generous guard against a hung handshake
    initial begin
        #40ms;
        $display("timeout waiting on the block");
        $display("Test completed with failures");
        $finish;
    end

    // result side monitor, sampled at the edge that accepts the beat
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got.status = o_status_code;
            got.failed = o_failed;
            got.epid   = o_entry_pid_out;
            got.emark  = o_entry_mark_out;
            got.cfg_ok = o_config_valid;
            got.tune   = o_tuning_needed;
            got.pidupd = o_pid_update_needed;
            sb.check_result(got);
        end
    end

    // result side stall: mostly short random, sometimes long, a long hold-off on each request
    initial begin
        int r;
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            r = $urandom_range(99);
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (400) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if (r < 55) begin
                // open stretch
                i_out_stall <= 1'b0;
                repeat ($urandom_range(1, 60)) @(posedge i_clk);
            end else begin
                n = (r < 95) ? $urandom_range(1, 4) : $urandom_range(20, 80);
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // one beat on the input channel; valid stays up unless a random gap follows (none when gapless)
    task automatic send_beat(logic [2:0] act, logic [12:0] pid, logic [3:0] sel,
                             logic [31:0] word, logic [4:0] esel);
        int gap;
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_stream_pid   <= pid;
        i_param_select <= sel;
        i_param_word   <= word;
        i_entry_select <= esel;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(act, pid, sel, word, esel);
        beats_sent++;
        gap = gapless ? 0 : $urandom_range(99);
        if (gap >= 60) begin
            i_in_valid <= 1'b0;
            repeat ((gap < 96) ? $urandom_range(1, 3) : $urandom_range(15, 60))
                @(posedge i_clk);
        end
    endtask

    // read entry beat, only for entries whose pid has been written
    task automatic read_beat();
        int k;
        k = sb.readable_slot();
        if (k < 0) send_beat(ACT_SETTLE, 13'($urandom), 4'($urandom), $urandom, 5'($urandom));
        else send_beat(ACT_READ, 13'($urandom), 4'($urandom), $urandom, k[4:0]);
    endtask

    task automatic param_beat(logic [3:0] sel, logic [31:0] word);
        send_beat(ACT_SETPAR, 13'($urandom), sel, word, 5'($urandom));
    endtask

    // idle point: waits until every pending result is back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (!sb.idle()) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // apb write of frontend_type: setup then access phase
    task automatic write_frontend(logic [1:0] ft);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= '0;
        pwdata  <= {30'd0, ft};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        sb.fe = ft;
        cfg_writes++;
    endtask

    // random parameter value: small values give frequent same-value rewrites
    function automatic logic [31:0] any_word();
        return ($urandom_range(3) == 0) ? $urandom : $urandom_range(3);
    endfunction

    // the modsys code a frontend accepts, sometimes a wrong one
    function automatic logic [31:0] modsys_for(logic [1:0] ft);
        if ($urandom_range(5) == 0) return $urandom_range(7);
        case (ft)
            FE_SAT:   return $urandom_range(1) ? MS_S2 : MS_S;
            FE_TERR:  return $urandom_range(1) ? MS_T2 : MS_T;
            FE_CABLE: return MS_C;
            default:  return $urandom_range(4);
        endcase
    endfunction

    // full tuning set in random order, some members skipped now and then
    task automatic tuning_sequence(logic [1:0] ft);
        logic [3:0] order[16];
        logic [3:0] t;
        int j;
        for (int i = 0; i < 16; i++) order[i] = 4'(i);
        for (int i = 15; i > 0; i--) begin
            j = $urandom_range(i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < 16; i++) begin
            if ($urandom_range(19) == 0) continue;
            if (order[i] == SEL_MODSYS) param_beat(order[i], modsys_for(ft));
            else param_beat(order[i], any_word());
        end
        if ($urandom_range(1))
            send_beat(ACT_SETTLE, 13'($urandom), 4'($urandom), $urandom, 5'($urandom));
    endtask

    // adds, deletes, delete-alls and reads over a mostly small pid pool, ending in a settle
    task automatic pid_sequence();
        int n;
        logic [12:0] pid;
        n = $urandom_range(3, 12);
        repeat (n) begin
            pid = ($urandom_range(7) == 0) ? 13'($urandom) : 13'($urandom_range(40));
            case ($urandom_range(9))
                0, 1, 2, 3: send_beat(ACT_ADD, pid, 4'($urandom), $urandom, 5'($urandom));
                4, 5, 6:    send_beat(ACT_DEL, pid, 4'($urandom), $urandom, 5'($urandom));
                7:          send_beat(ACT_DELALL, pid, 4'($urandom), $urandom, 5'($urandom));
                default:    read_beat();
            endcase
        end
        send_beat(ACT_SETTLE, 13'($urandom), 4'($urandom), $urandom, 5'($urandom));
    endtask

    // enough distinct adds to run the table full
    task automatic fill_sequence();
        logic [12:0] base;
        base = 13'($urandom);
        for (int i = 0; i < 35; i++)
            send_beat(ACT_ADD, base + 13'(i), 4'($urandom), $urandom, 5'($urandom));
        read_beat();
    endtask

    // lone beats of any kind, clears mostly turned into settles, other fields random
    task automatic noise_beat();
        logic [2:0] act;
        act = 3'($urandom);
        if (act == ACT_READ) read_beat();
        else if (act == ACT_CLEAR && $urandom_range(3) != 0)
            send_beat(ACT_SETTLE, 13'($urandom), 4'($urandom), $urandom, 5'($urandom));
        else send_beat(act, 13'($urandom), 4'($urandom), $urandom, 5'($urandom));
    endtask

    // one random phase under a given frontend type
    task automatic random_phase(logic [1:0] ft, int quota, bit squeeze);
        int stop;
        int r;
        stop = beats_sent + quota;
        if (squeeze) hold_req = 1;
        while (beats_sent < stop) begin
            gapless = ($urandom_range(9) == 0);
            r = $urandom_range(99);
            if (r < 30) tuning_sequence(ft);
            else if (r < 75) pid_sequence();
            else if (r < 80) fill_sequence();
            else if (r < 83) begin
                send_beat(ACT_LNBOFF, 13'($urandom), 4'($urandom), $urandom, 5'($urandom));
                param_beat(SEL_POL, any_word());
            end else noise_beat();
        end
        gapless = 0;
    endtask

    initial begin
        logic [1:0] plan[8];
        sb         = new();
        hold_req   = 0;
        gapless    = 0;
        beats_sent = 0;
        cfg_writes = 0;
        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_action       <= '0;
        i_stream_pid   <= '0;
        i_param_select <= '0;
        i_param_word   <= '0;
        i_entry_select <= '0;
        psel           <= 1'b0;
        penable        <= 1'b0;
        pwrite         <= 1'b0;
        paddr          <= '0;
        pwdata         <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: satellite system, pid extremes, revive, delete all, lnb off, clear
        write_frontend(FE_SAT);
        send_beat(ACT_SETTLE, '0, '0, '0, '0);          // incomplete settle fails
        send_beat(ACT_ADD, 13'd0, '0, '0, '0);
        send_beat(ACT_ADD, 13'h1fff, '1, '1, '1);
        send_beat(ACT_ADD, 13'd0, '0, '0, '0);          // already live
        send_beat(ACT_DEL, 13'h1fff, '0, '0, '0);       // frees a pending add
        param_beat(4'd0, 32'hffff_ffff);
        param_beat(SEL_POL, 32'd1);
        param_beat(SEL_MODSYS, MS_S);
        param_beat(4'd6, 32'd27500);
        param_beat(4'd7, 32'd2);
        param_beat(4'd8, 32'd0);                         // now complete
        param_beat(4'd8, 32'd0);                         // same value again
        send_beat(ACT_SETTLE, '0, '0, '0, '0);
        send_beat(ACT_DEL, 13'd0, '0, '0, '0);           // pending delete
        send_beat(ACT_ADD, 13'd0, '0, '0, '0);           // revived
        send_beat(ACT_DELALL, '0, '0, '0, '0);
        send_beat(ACT_READ, '0, '0, '0, 5'd0);
        send_beat(ACT_LNBOFF, '0, '0, '0, '0);
        param_beat(SEL_POL, 32'd1);                      // lnb back on, re-evaluated
        param_beat(4'd15, 32'd0);
        send_beat(ACT_CLEAR, '0, '0, '0, '0);
        send_beat(ACT_READ, '0, '0, '0, 5'd1);
        drain();

        plan = '{2'd3, FE_SAT, FE_TERR, FE_CABLE, FE_SAT, FE_TERR, FE_CABLE, 2'd3};
        for (int p = 0; p < 8; p++) begin
            write_frontend(plan[p]);
            random_phase(plan[p], 240, p == 2 || p == 5);
            drain();                                     // sender waits for every result
        end

        $display("covered %0d input beats, %0d result beats, %0d frontend type writes",
                 beats_sent, sb.results, cfg_writes);
        $display("all four frontend types, table overflow, and lnb/clear paths exercised");
        if (sb.errors == 0 && sb.idle()) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d mismatches, %0d results never came", sb.errors, sb.pending_q.size());
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
